// ===== hw/rtl/aen_pkg.sv =====
// Shared types, constants and token tables for the Accept-Encoding negotiator.
`timescale 1ns / 1ps

package aen_pkg;

    localparam int NUM_TOKENS = 3;
    localparam int TOK_POS    = 4;
    localparam int LEN_W      = 3;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int TOK_BR   = 0;
    localparam int TOK_ZSTD = 1;
    localparam int TOK_GZIP = 2;

    localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(5);

    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_BROTLI = 2'd0;
    localparam logic [1:0] REG_ZSTD   = 2'd1;
    localparam logic [1:0] REG_GZIP   = 2'd2;

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_COMMA,
        CLS_SPACE,
        CLS_TAB,
        CLS_SEMI,
        CLS_Q,
        CLS_EQ,
        CLS_ZERO,
        CLS_DOT
    } byte_class_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_CODING,
        PH_TRAIL,
        PH_PARAM
    } phase_t;

    typedef enum logic [1:0] {
        QZ_IDLE,
        QZ_Q,
        QZ_EQ,
        QZ_ZERO
    } qzero_stage_t;

    typedef enum logic [1:0] {
        ENC_IDENTITY = 2'd0,
        ENC_GZIP     = 2'd1,
        ENC_BROTLI   = 2'd2,
        ENC_ZSTD     = 2'd3
    } encoding_t;

    typedef struct packed {
        byte_class_t                          cls;
        logic [NUM_TOKENS-1:0][TOK_POS-1:0]   hit;
        logic                                 present;
        logic                                 last;
    } item_t;

    typedef struct packed {
        logic brotli;
        logic zstd;
        logic gzip;
    } enable_t;

    function automatic logic [LEN_W-1:0] tok_len(input int t);
        logic [LEN_W-1:0] len;
        case (t)
            TOK_BR:   len = LEN_W'(2);
            TOK_ZSTD: len = LEN_W'(4);
            TOK_GZIP: len = LEN_W'(4);
            default:  len = LEN_SAT;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] tok_char(input int t, input int pos);
        logic [7:0] c;
        c = 8'h00;
        case (t)
            TOK_BR: begin
                case (pos)
                    0:       c = "b";
                    1:       c = "r";
                    default: c = 8'h00;
                endcase
            end
            TOK_ZSTD: begin
                case (pos)
                    0:       c = "z";
                    1:       c = "s";
                    2:       c = "t";
                    default: c = "d";
                endcase
            end
            TOK_GZIP: begin
                case (pos)
                    0:       c = "g";
                    1:       c = "z";
                    2:       c = "i";
                    default: c = "p";
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/accept_encoding_negotiator.sv =====
// Top level: APB enable registers, front end, beat queue and back end.
`timescale 1ns / 1ps

// Takes one Accept-Encoding header byte per beat, with byte_present and
// end_of_header flags, and returns one chosen_encoding (0 identity, 1 gzip,
// 2 brotli, 3 zstd) for each beat that carries end_of_header. Sustained rate
// is one beat per cycle, set by the back-end character state machine that
// retires one queued beat each cycle unless an end beat waits for a held
// result. The result is registered as the back end takes the end beat; while
// a result waits to be taken, the back end holds only the next end beat and
// the front end keeps filling the queue of QUEUE_DEPTH beats. Enable registers
// sit at byte addresses 0 (brotli), 4 (zstd) and 8 (gzip), bit 0, reset to 1.

module accept_encoding_negotiator
    import aen_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,

    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_header_byte,
    input  logic              s_byte_present,
    input  logic              s_end_of_header,

    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_chosen_encoding
);

    logic    brotli_enabled_reg;
    logic    zstd_enabled_reg;
    logic    gzip_enabled_reg;
    logic    cfg_write;
    enable_t enables;

    item_t   front_item;
    item_t   q_item;
    logic    q_full;
    logic    q_valid;
    logic    q_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brotli_enabled_reg <= 1'b1;
            zstd_enabled_reg   <= 1'b1;
            gzip_enabled_reg   <= 1'b1;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_BROTLI: brotli_enabled_reg <= pwdata[0];
                REG_ZSTD:   zstd_enabled_reg   <= pwdata[0];
                REG_GZIP:   gzip_enabled_reg   <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_BROTLI: prdata = {31'd0, brotli_enabled_reg};
            REG_ZSTD:   prdata = {31'd0, zstd_enabled_reg};
            REG_GZIP:   prdata = {31'd0, gzip_enabled_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign enables.brotli = brotli_enabled_reg;
    assign enables.zstd   = zstd_enabled_reg;
    assign enables.gzip   = gzip_enabled_reg;

    assign s_ready = !q_full;

    aen_front u_front (
        .header_byte   (s_header_byte),
        .byte_present  (s_byte_present),
        .end_of_header (s_end_of_header),
        .item          (front_item)
    );

    aen_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_item  (front_item),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .rd_pop   (q_pop)
    );

    aen_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .enables           (enables),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_chosen_encoding (m_chosen_encoding)
    );

endmodule

// ===== hw/rtl/aen_front.sv =====
// Front end: classifies each header byte and precomputes token character hits.
`timescale 1ns / 1ps

module aen_front
    import aen_pkg::*;
(
    input  logic [7:0] header_byte,
    input  logic       byte_present,
    input  logic       end_of_header,
    output item_t      item
);

    logic [7:0]  lc;
    byte_class_t cls;

    always_comb begin
        if (header_byte >= "A" && header_byte <= "Z") begin
            lc = header_byte + 8'd32;
        end else begin
            lc = header_byte;
        end
    end

    // class uses the raw byte: the q=0 search is case-sensitive
    always_comb begin
        unique case (header_byte)
            ",":     cls = CLS_COMMA;
            " ":     cls = CLS_SPACE;
            8'h09:   cls = CLS_TAB;
            ";":     cls = CLS_SEMI;
            "q":     cls = CLS_Q;
            "=":     cls = CLS_EQ;
            "0":     cls = CLS_ZERO;
            ".":     cls = CLS_DOT;
            default: cls = CLS_OTHER;
        endcase
    end

    always_comb begin
        item.cls     = cls;
        item.present = byte_present;
        item.last    = end_of_header;
        for (int t = 0; t < NUM_TOKENS; t++) begin
            for (int p = 0; p < TOK_POS; p++) begin
                item.hit[t][p] = (LEN_W'(p) < tok_len(t)) && (lc == tok_char(t, p));
            end
        end
    end

endmodule

// ===== hw/rtl/aen_queue.sv =====
// Short FIFO of classified beats between the front end and the back end.
`timescale 1ns / 1ps

module aen_queue
    import aen_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  wr_valid,
    input  item_t wr_item,
    output logic  full,
    output logic  rd_valid,
    output item_t rd_item,
    input  logic  rd_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && !full;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !rd_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && rd_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== hw/rtl/aen_back.sv =====
// Back end: header parse state machine, token verdicts and the result register.
`timescale 1ns / 1ps

module aen_back
    import aen_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    input  item_t     q_item,
    output logic      q_pop,
    input  enable_t   enables,
    output logic      m_valid,
    input  logic      m_ready,
    output logic [1:0] m_chosen_encoding
);

    typedef struct packed {
        logic [NUM_TOKENS-1:0] decided;
        logic [NUM_TOKENS-1:0] accepted;
    } verdict_t;

    phase_t                phase_reg, phase_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [NUM_TOKENS-1:0] mism_reg, mism_next;
    qzero_stage_t          stage_reg, stage_next;
    logic                  qs_reg, qs_next;
    logic                  qds_reg, qds_next;
    verdict_t              verdict_reg, verdict_next;
    logic                  any_reg, any_next;
    encoding_t             enc_next;

    logic                  m_valid_reg, m_valid_next;
    encoding_t             m_enc_reg, m_enc_next;

    logic [LEN_W-1:0]      cc_len;
    logic [NUM_TOKENS-1:0] cc_mism;

    function automatic verdict_t end_item(
        input phase_t                ph,
        input logic                  qs,
        input logic                  qds,
        input logic [LEN_W-1:0]      len,
        input logic [NUM_TOKENS-1:0] mism,
        input verdict_t              v_in
    );
        verdict_t v;
        logic     refused;
        v       = v_in;
        refused = (ph == PH_PARAM) && qs && !qds;
        for (int t = 0; t < NUM_TOKENS; t++) begin
            if (!v.decided[t] && !mism[t] && len == tok_len(t)) begin
                v.decided[t] = 1'b1;
                if (!refused) begin
                    v.accepted[t] = 1'b1;
                end
            end
        end
        return v;
    endfunction

    // one coding character against every token at the current position
    always_comb begin
        cc_mism = mism_reg;
        for (int t = 0; t < NUM_TOKENS; t++) begin
            if (len_reg >= tok_len(t) || !q_item.hit[t][len_reg[1:0]]) begin
                cc_mism[t] = 1'b1;
            end
        end
        cc_len = (len_reg < LEN_SAT) ? len_reg + 1'b1 : len_reg;
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        len_next     = len_reg;
        mism_next    = mism_reg;
        stage_next   = stage_reg;
        qs_next      = qs_reg;
        qds_next     = qds_reg;
        verdict_next = verdict_reg;
        any_next     = any_reg;
        enc_next     = ENC_IDENTITY;

        if (q_item.present) begin
            any_next = 1'b1;
            if (q_item.cls == CLS_COMMA) begin
                verdict_next = end_item(phase_reg, qs_reg, qds_reg, len_reg, mism_reg,
                                        verdict_reg);
                phase_next = PH_LEAD;
                len_next   = '0;
                mism_next  = '0;
                stage_next = QZ_IDLE;
                qs_next    = 1'b0;
                qds_next   = 1'b0;
            end else begin
                unique case (phase_reg)
                    PH_LEAD: begin
                        if (q_item.cls == CLS_SEMI) begin
                            phase_next = PH_PARAM;
                        end else if (q_item.cls != CLS_SPACE && q_item.cls != CLS_TAB) begin
                            phase_next = PH_CODING;
                            len_next   = cc_len;
                            mism_next  = cc_mism;
                        end
                    end
                    PH_CODING: begin
                        if (q_item.cls == CLS_SEMI) begin
                            phase_next = PH_PARAM;
                        end else if (q_item.cls == CLS_SPACE) begin
                            phase_next = PH_TRAIL;
                        end else begin
                            len_next  = cc_len;
                            mism_next = cc_mism;
                        end
                    end
                    PH_TRAIL: begin
                        if (q_item.cls == CLS_SEMI) begin
                            phase_next = PH_PARAM;
                        end else if (q_item.cls != CLS_SPACE) begin
                            // space inside a coding: matches nothing
                            mism_next  = '1;
                            phase_next = PH_CODING;
                        end
                    end
                    PH_PARAM: begin
                        if (stage_reg == QZ_Q && q_item.cls == CLS_EQ) begin
                            stage_next = QZ_EQ;
                        end else if (stage_reg == QZ_EQ && q_item.cls == CLS_ZERO) begin
                            stage_next = QZ_ZERO;
                            qs_next    = 1'b1;
                        end else if (stage_reg == QZ_ZERO && q_item.cls == CLS_DOT) begin
                            stage_next = QZ_IDLE;
                            qds_next   = 1'b1;
                        end else begin
                            stage_next = (q_item.cls == CLS_Q) ? QZ_Q : QZ_IDLE;
                        end
                    end
                endcase
            end
        end

        if (q_item.last) begin
            verdict_next = end_item(phase_next, qs_next, qds_next, len_next, mism_next,
                                    verdict_next);
            if (any_next) begin
                if (enables.brotli && verdict_next.accepted[TOK_BR]) begin
                    enc_next = ENC_BROTLI;
                end else if (enables.zstd && verdict_next.accepted[TOK_ZSTD]) begin
                    enc_next = ENC_ZSTD;
                end else if (enables.gzip && verdict_next.accepted[TOK_GZIP]) begin
                    enc_next = ENC_GZIP;
                end
            end
            phase_next   = PH_LEAD;
            len_next     = '0;
            mism_next    = '0;
            stage_next   = QZ_IDLE;
            qs_next      = 1'b0;
            qds_next     = 1'b0;
            verdict_next = '0;
            any_next     = 1'b0;
        end
    end

    // outputs: a beat ending the header waits only while a held result is not yet taken
    always_comb begin
        q_pop        = q_valid && (!q_item.last || !m_valid_reg || m_ready);
        m_valid_next = m_valid_reg && !m_ready;
        m_enc_next   = m_enc_reg;
        if (q_pop && q_item.last) begin
            m_valid_next = 1'b1;
            m_enc_next   = enc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            len_reg     <= '0;
            mism_reg    <= '0;
            stage_reg   <= QZ_IDLE;
            qs_reg      <= 1'b0;
            qds_reg     <= 1'b0;
            verdict_reg <= '0;
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (q_pop) begin
                phase_reg   <= phase_next;
                len_reg     <= len_next;
                mism_reg    <= mism_next;
                stage_reg   <= stage_next;
                qs_reg      <= qs_next;
                qds_reg     <= qds_next;
                verdict_reg <= verdict_next;
                any_reg     <= any_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_enc_reg <= m_enc_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_chosen_encoding = m_enc_reg;

endmodule
